>>> sv/alarm_buzzer_priority_sequencer_macros.svh
// assertion macros for the alarm buzzer priority sequencer
`ifndef ALARM_BUZZER_PRIORITY_SEQUENCER_MACROS_SVH
`define ALARM_BUZZER_PRIORITY_SEQUENCER_MACROS_SVH

// condition implies consequence in the same cycle, checked out of reset
`define ABPS_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle, checked out of reset
`define ABPS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/abps_pkg.sv
// shared types and constants of the alarm buzzer priority sequencer
`timescale 1ns / 1ps
`default_nettype none
package abps_pkg;

  // burst counter width
  localparam int CNT_W = 16;
  // configuration register width and index width
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BURST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_BURST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BURST    = 2'd2;

  // item kinds
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // alarm levels, codes 5..7 carry no meaning
  typedef enum logic [2:0] {
    LVL_IDLE    = 3'd0,
    LVL_LOW     = 3'd1,
    LVL_MEDIUM  = 3'd2,
    LVL_HIGH    = 3'd3,
    LVL_INHIBIT = 3'd4
  } level_t;

  // buzzer patterns
  localparam logic [1:0] PAT_SILENT    = 2'd0;
  localparam logic [1:0] PAT_VERY_SLOW = 2'd1;
  localparam logic [1:0] PAT_SLOW      = 2'd2;
  localparam logic [1:0] PAT_FAST      = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] alarm_level;
    logic       beep_running;
  } item_t;

  typedef struct packed {
    logic       sound_update;
    logic [1:0] sound_pattern;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // which burst counters are still running
  typedef struct packed {
    logic hi_busy;
    logic md_busy;
    logic lo_busy;
  } cnt_status_t;

  // register value to counter load value, low bits kept
  function automatic cnt_t to_cnt(input logic [CFG_W-1:0] v);
    return CNT_W'(v);
  endfunction

endpackage
`default_nettype wire

>>> sv/abps_ifs.sv
// valid/ready channel interfaces for command beats and result beats
`timescale 1ns / 1ps
`default_nettype none
interface abps_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] alarm_level;
  logic       beep_running;

  modport source (output valid, output kind, output alarm_level, output beep_running,
                  input ready);
  modport sink (input valid, input kind, input alarm_level, input beep_running,
                output ready);
endinterface

interface abps_out_if;
  logic       valid;
  logic       ready;
  logic       sound_update;
  logic [1:0] sound_pattern;

  modport source (output valid, output sound_update, output sound_pattern, input ready);
  modport sink (input valid, input sound_update, input sound_pattern, output ready);
endinterface
`default_nettype wire

>>> sv/abps_in_stage.sv
// input register that captures one command or tick beat
`timescale 1ns / 1ps
`default_nettype none
module abps_in_stage
  import abps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  abps_in_if.sink    in_ch,
  input  wire logic  advance,
  output item_t      item,
  output logic       item_valid
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // take a new beat when empty or when the held beat moves on
  assign in_ch.ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind         <= in_ch.kind;
      item_r.alarm_level  <= in_ch.alarm_level;
      item_r.beep_running <= in_ch.beep_running;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule
`default_nettype wire

>>> sv/abps_core.sv
// burst counters, remembered level and pattern decision
`timescale 1ns / 1ps
`default_nettype none
module abps_core
  import abps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_wr_t cfg,
  input  wire logic    advance,
  input  wire item_t   item,
  output result_t      result,
  output cnt_status_t  status
);

  logic [CFG_W-1:0] hi_ticks_r, md_ticks_r, lo_ticks_r;
  level_t           level_r, level_nxt;
  cnt_t             hi_cnt_r, hi_cnt_nxt;
  cnt_t             md_cnt_r, md_cnt_nxt;
  cnt_t             lo_cnt_r, lo_cnt_nxt;
  logic             hi_z, md_z, lo_z;

  // burst length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_ticks_r <= CFG_W'(1000);
      md_ticks_r <= CFG_W'(1000);
      lo_ticks_r <= CFG_W'(1000);
    end else if (cfg.we) begin
      case (cfg.idx)
        REG_HIGH_BURST:   hi_ticks_r <= cfg.data;
        REG_MEDIUM_BURST: md_ticks_r <= cfg.data;
        REG_LOW_BURST:    lo_ticks_r <= cfg.data;
        default: ;
      endcase
    end
  end

  assign hi_z = (hi_cnt_r == '0);
  assign md_z = (md_cnt_r == '0);
  assign lo_z = (lo_cnt_r == '0);

  // decision for the beat held in the input register
  always_comb begin
    level_nxt            = level_r;
    hi_cnt_nxt           = hi_cnt_r;
    md_cnt_nxt           = md_cnt_r;
    lo_cnt_nxt           = lo_cnt_r;
    result.sound_update  = 1'b0;
    result.sound_pattern = PAT_SILENT;
    if (item.kind == KIND_TICK) begin
      if (!hi_z) hi_cnt_nxt = hi_cnt_r - CNT_W'(1);
      if (!md_z) md_cnt_nxt = md_cnt_r - CNT_W'(1);
      if (!lo_z) lo_cnt_nxt = lo_cnt_r - CNT_W'(1);
    end else if (item.beep_running) begin
      level_nxt = LVL_IDLE;
    end else begin
      case (item.alarm_level)
        LVL_HIGH: begin
          if (md_z && lo_z && level_r != LVL_HIGH) begin
            result.sound_update  = 1'b1;
            result.sound_pattern = PAT_FAST;
            level_nxt            = LVL_HIGH;
            hi_cnt_nxt           = to_cnt(hi_ticks_r);
          end
        end
        LVL_MEDIUM: begin
          if (hi_z && lo_z && level_r != LVL_MEDIUM) begin
            result.sound_update  = 1'b1;
            result.sound_pattern = PAT_SLOW;
            level_nxt            = LVL_MEDIUM;
            md_cnt_nxt           = to_cnt(md_ticks_r);
          end
        end
        LVL_LOW: begin
          if (hi_z && md_z && level_r != LVL_LOW) begin
            result.sound_update  = 1'b1;
            result.sound_pattern = PAT_VERY_SLOW;
            level_nxt            = LVL_LOW;
            lo_cnt_nxt           = to_cnt(lo_ticks_r);
          end
        end
        LVL_IDLE: begin
          if (hi_z && md_z && lo_z && level_r != LVL_IDLE) begin
            result.sound_update  = 1'b1;
            result.sound_pattern = PAT_SILENT;
            level_nxt            = LVL_IDLE;
          end
        end
        LVL_INHIBIT: begin
          result.sound_update  = 1'b1;
          result.sound_pattern = PAT_SILENT;
          level_nxt            = LVL_INHIBIT;
        end
        default: ;
      endcase
    end
  end

  // state moves only when the beat goes to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= LVL_IDLE;
      hi_cnt_r <= '0;
      md_cnt_r <= '0;
      lo_cnt_r <= '0;
    end else if (advance) begin
      level_r  <= level_nxt;
      hi_cnt_r <= hi_cnt_nxt;
      md_cnt_r <= md_cnt_nxt;
      lo_cnt_r <= lo_cnt_nxt;
    end
  end

  assign status.hi_busy = !hi_z;
  assign status.md_busy = !md_z;
  assign status.lo_busy = !lo_z;

endmodule
`default_nettype wire

>>> sv/abps_out_stage.sv
// result register driving the output channel
`timescale 1ns / 1ps
`default_nettype none
module abps_out_stage
  import abps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    advance,
  input  wire result_t result,
  output logic         space,
  abps_out_if.source   out_ch
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  // room for a new result when empty or being drained
  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.sound_update  = result_r.sound_update;
  assign out_ch.sound_pattern = result_r.sound_pattern;

endmodule
`default_nettype wire

>>> sv/alarm_buzzer_priority_sequencer.sv
// alarm buzzer priority sequencer: top level
// path: an accepted beat is held in the input register, then its result is written
//   into the result register, from which the output channel takes the result beat
// throughput: one beat per cycle while the output channel takes results, set by the
//   single decision stage between the input register and the result register
// reset: synchronous active-low rst_n empties both registers, clears the counters,
//   sets the remembered level to idle and the burst lengths to 1000
`timescale 1ns / 1ps
`default_nettype none
`include "alarm_buzzer_priority_sequencer_macros.svh"
module alarm_buzzer_priority_sequencer
  import abps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  abps_in_if.sink                   in_ch,
  abps_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  item_t       item;
  logic        item_valid;
  logic        space;
  logic        advance;
  result_t     result;
  cnt_status_t status;
  cfg_wr_t     cfg;
  logic        tick_adv;
  logic        out_quiet;
  logic        stall_both;

  // a held beat moves on when the result register has room
  assign advance = item_valid && space;

  assign cfg.we   = cfg_we;
  assign cfg.idx  = cfg_idx;
  assign cfg.data = cfg_wdata;

  abps_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item       (item),
    .item_valid (item_valid)
  );

  abps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .item    (item),
    .result  (result),
    .status  (status)
  );

  abps_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .result  (result),
    .space   (space),
    .out_ch  (out_ch)
  );

  // terms used by the checks
  assign tick_adv   = advance && item.kind == KIND_TICK;
  assign out_quiet  = out_ch.valid && !out_ch.sound_update;
  assign stall_both = item_valid && out_ch.valid && !out_ch.ready;

  // checks
  `ABPS_ASSERT_SAME(a_one_burst, 1'b1, $countones(status) <= 1, "more than one burst running")
  `ABPS_ASSERT_NEXT(a_tick_silent, tick_adv, out_quiet, "tick beat commanded a sound")
  `ABPS_ASSERT_SAME(a_stall_blocks, stall_both, !in_ch.ready, "input taken while stalled")
  `ABPS_ASSERT_SAME(a_pat_quiet, out_quiet, out_ch.sound_pattern == PAT_SILENT, "stray pattern")

endmodule
`default_nettype wire
